@@ rtl/core/dtq_pkg.sv @@
// shared types and constants of the deadline timer queue
// used by the interfaces, controller, datapath and top level; no dependencies
package dtq_pkg;

   localparam int QueueDepth = 16;
   localparam int MaxFire    = 16;
   localparam int AddrW      = $clog2(QueueDepth);
   localparam int CntW       = $clog2(QueueDepth + 1);
   localparam int TagW       = 16;

   // operation codes
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRE   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FIRED     = 3'd4;
   localparam logic [2:0] ST_NOTHING   = 3'd5;

   // pointer operations
   localparam logic [2:0] PTR_HOLD  = 3'd0;
   localparam logic [2:0] PTR_ZERO  = 3'd1;
   localparam logic [2:0] PTR_INC   = 3'd2;
   localparam logic [2:0] PTR_DEC   = 3'd3;
   localparam logic [2:0] PTR_COUNT = 3'd4;

   // read address selects
   localparam logic [1:0] RD_PTR    = 2'd0;
   localparam logic [1:0] RD_PTR_M1 = 2'd1;
   localparam logic [1:0] RD_PTR_P1 = 2'd2;
   localparam logic [1:0] RD_TOP    = 2'd3;

   // count operations
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_FIRE = 2'd3;

   typedef struct packed {
      logic [31:0]     start;
      logic [30:0]     delay;
      logic [TagW-1:0] tag;
      logic [31:0]     id;
   } entry_type;

   typedef struct packed {
      logic       latch;
      logic [2:0] ptr_op;
      logic       pos_load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic [1:0] cnt_op;
      logic       fire_load;
      logic       res_set;
      logic [2:0] res_status;
      logic       res_use_id;
      logic       ttn_clear;
      logic       ttn_load;
      logic       out_load;
      logic       out_fire;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic ptr_eq_count;
      logic ptr_eq_pos;
      logic ptr_p1_eq_count;
      logic ptr_eq_max;
      logic rem_lt_delay;
      logic id_match;
      logic expired;
      logic is_fire;
      logic fire_nz;
      logic ptr_p1_eq_fire;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/core/dtq_if.sv @@
// request and response channel interfaces of the deadline timer queue
// depends on dtq_pkg for the tag width
interface dtq_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [31:0]               now_ms;
   logic signed [31:0]        delay_ms;
   logic [dtq_pkg::TagW-1:0]  tag;
   logic [31:0]               cancel_id;

   modport source (output valid, kind, now_ms, delay_ms, tag, cancel_id, input ready);
   modport sink   (input valid, kind, now_ms, delay_ms, tag, cancel_id, output ready);
endinterface

interface dtq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                status;
   logic [31:0]               timer_id;
   logic [dtq_pkg::TagW-1:0]  event_tag;
   logic                      last;
   logic                      queue_empty;
   logic [30:0]               time_to_next;

   modport source (output valid, status, timer_id, event_tag, last, queue_empty,
                   time_to_next, input ready);
   modport sink   (input valid, status, timer_id, event_tag, last, queue_empty,
                   time_to_next, output ready);
endinterface

@@ rtl/core/deadline_timer_queue.sv @@
// deadline timer queue: a queue of pending timers kept in order of remaining time
// Channels: req_bus carries one operation per beat (add, cancel, fire) with the
// current ms time; rsp_bus returns result beats, the final one of an item marked
// last. Each result reports whether the queue is empty and the head's time to
// expiry after the whole operation.
// One item is worked on at a time; the slot memory has one read and one write
// port with a registered read, so every scanned or shifted slot takes a read
// state and then a compare or write state. An add scans from the slot with the
// most time left for its place and shifts the later slots up; an add to a full
// queue does no scan. A cancel scans for the id and shifts the later slots down.
// A fire scans the expired timers and reads the new head, then sends one beat
// per fired timer, or a single beat when nothing expired.
// The next item is taken once the last beat of the current one has been
// loaded into the output register, which holds while rsp_bus.ready is low;
// the sequencer waits in place when that register is still occupied.
// Reset empties the queue and sets the next id to one; no clearing pass runs.
// depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_dpath
module deadline_timer_queue (
   input  logic       clock,
   input  logic       reset,
   dtq_req_if.sink    req_bus,
   dtq_rsp_if.source  rsp_bus
);

   dtq_pkg::cmd_type  cmd;
   dtq_pkg::stat_type stat;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dtq_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_bus.kind),
      .req_now_ms       (req_bus.now_ms),
      .req_delay_ms     (req_bus.delay_ms),
      .req_tag          (req_bus.tag),
      .req_cancel_id    (req_bus.cancel_id),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_timer_id     (rsp_bus.timer_id),
      .rsp_event_tag    (rsp_bus.event_tag),
      .rsp_last         (rsp_bus.last),
      .rsp_queue_empty  (rsp_bus.queue_empty),
      .rsp_time_to_next (rsp_bus.time_to_next)
   );

endmodule

@@ rtl/core/dtq_ctrl.sv @@
// sequencer of the deadline timer queue: scans, shifts, fire pops and result beats
// depends on dtq_pkg for the command and status structs
module dtq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_kind,
   output logic               req_ready,
   input  dtq_pkg::stat_type  stat,
   output dtq_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_A_RD  = 4'd1;
   localparam logic [3:0] S_A_CMP = 4'd2;
   localparam logic [3:0] S_S_RD  = 4'd3;
   localparam logic [3:0] S_S_WR  = 4'd4;
   localparam logic [3:0] S_C_RD  = 4'd5;
   localparam logic [3:0] S_C_CMP = 4'd6;
   localparam logic [3:0] S_D_RD  = 4'd7;
   localparam logic [3:0] S_D_WR  = 4'd8;
   localparam logic [3:0] S_F_RD  = 4'd9;
   localparam logic [3:0] S_F_CMP = 4'd10;
   localparam logic [3:0] S_T_RD  = 4'd11;
   localparam logic [3:0] S_T_LD  = 4'd12;
   localparam logic [3:0] S_O_ONE = 4'd13;
   localparam logic [3:0] S_E_RD  = 4'd14;
   localparam logic [3:0] S_E_LD  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [3:0] after_ttn;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign after_ttn = (stat.is_fire && stat.fire_nz) ? S_E_RD : S_O_ONE;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch  = 1'b1;
               cmd.ptr_op = dtq_pkg::PTR_ZERO;
               priority if (req_kind == dtq_pkg::KIND_ADD) begin
                  if (stat.count_full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = dtq_pkg::ST_FULL;
                     state_in       = S_T_RD;
                  end else begin
                     state_in = S_A_RD;
                  end
               end else if (req_kind == dtq_pkg::KIND_CANCEL) begin
                  state_in = S_C_RD;
               end else if (req_kind == dtq_pkg::KIND_FIRE) begin
                  state_in = S_F_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_A_RD: begin
            if (stat.ptr_eq_count) begin
               cmd.pos_load = 1'b1;
               cmd.ptr_op   = dtq_pkg::PTR_COUNT;
               state_in     = S_S_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_PTR;
               state_in   = S_A_CMP;
            end
         end
         S_A_CMP: begin
            if (stat.rem_lt_delay) begin
               cmd.pos_load = 1'b1;
               cmd.ptr_op   = dtq_pkg::PTR_COUNT;
               state_in     = S_S_RD;
            end else begin
               cmd.ptr_op = dtq_pkg::PTR_INC;
               state_in   = S_A_RD;
            end
         end
         S_S_RD: begin
            if (stat.ptr_eq_pos) begin
               cmd.wr_en      = 1'b1;
               cmd.wr_new     = 1'b1;
               cmd.cnt_op     = dtq_pkg::CNT_INC;
               cmd.res_set    = 1'b1;
               cmd.res_status = dtq_pkg::ST_ADDED;
               cmd.res_use_id = 1'b1;
               cmd.ptr_op     = dtq_pkg::PTR_ZERO;
               state_in       = S_T_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_PTR_M1;
               state_in   = S_S_WR;
            end
         end
         S_S_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = dtq_pkg::PTR_DEC;
            state_in   = S_S_RD;
         end
         S_C_RD: begin
            if (stat.ptr_eq_count) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = dtq_pkg::ST_NOT_FOUND;
               cmd.ptr_op     = dtq_pkg::PTR_ZERO;
               state_in       = S_T_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_PTR;
               state_in   = S_C_CMP;
            end
         end
         S_C_CMP: begin
            if (stat.id_match) begin
               state_in = S_D_RD;
            end else begin
               cmd.ptr_op = dtq_pkg::PTR_INC;
               state_in   = S_C_RD;
            end
         end
         S_D_RD: begin
            if (stat.ptr_p1_eq_count) begin
               cmd.cnt_op     = dtq_pkg::CNT_DEC;
               cmd.res_set    = 1'b1;
               cmd.res_status = dtq_pkg::ST_CANCELLED;
               cmd.ptr_op     = dtq_pkg::PTR_ZERO;
               state_in       = S_T_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_PTR_P1;
               state_in   = S_D_WR;
            end
         end
         S_D_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = dtq_pkg::PTR_INC;
            state_in   = S_D_RD;
         end
         S_F_RD: begin
            if (stat.ptr_eq_count || stat.ptr_eq_max) begin
               cmd.fire_load  = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = dtq_pkg::ST_NOTHING;
               state_in       = S_T_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_TOP;
               state_in   = S_F_CMP;
            end
         end
         S_F_CMP: begin
            if (stat.expired) begin
               cmd.ptr_op = dtq_pkg::PTR_INC;
               state_in   = S_F_RD;
            end else begin
               cmd.fire_load  = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = dtq_pkg::ST_NOTHING;
               state_in       = S_T_RD;
            end
         end
         // head after the item sits at count-1-ptr
         S_T_RD: begin
            if (stat.ptr_eq_count) begin
               cmd.ttn_clear = 1'b1;
               if (after_ttn == S_E_RD) begin
                  cmd.ptr_op = dtq_pkg::PTR_ZERO;
               end
               state_in = after_ttn;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dtq_pkg::RD_TOP;
               state_in   = S_T_LD;
            end
         end
         S_T_LD: begin
            cmd.ttn_load = 1'b1;
            if (after_ttn == S_E_RD) begin
               cmd.ptr_op = dtq_pkg::PTR_ZERO;
            end
            state_in = after_ttn;
         end
         S_O_ONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_E_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = dtq_pkg::RD_TOP;
            state_in   = S_E_LD;
         end
         S_E_LD: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_fire = 1'b1;
               cmd.out_last = stat.ptr_p1_eq_fire;
               if (stat.ptr_p1_eq_fire) begin
                  cmd.cnt_op = dtq_pkg::CNT_FIRE;
                  state_in   = S_IDLE;
               end else begin
                  cmd.ptr_op = dtq_pkg::PTR_INC;
                  state_in   = S_E_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/dtq_dpath.sv @@
// datapath of the deadline timer queue: slot memory, pointers, time math, result register
// depends on dtq_pkg for entry, command and status types
module dtq_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  dtq_pkg::cmd_type          cmd,
   output dtq_pkg::stat_type         stat,
   input  logic [1:0]                req_kind,
   input  logic [31:0]               req_now_ms,
   input  logic signed [31:0]        req_delay_ms,
   input  logic [dtq_pkg::TagW-1:0]  req_tag,
   input  logic [31:0]               req_cancel_id,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [31:0]               rsp_timer_id,
   output logic [dtq_pkg::TagW-1:0]  rsp_event_tag,
   output logic                      rsp_last,
   output logic                      rsp_queue_empty,
   output logic [30:0]               rsp_time_to_next
);

   localparam logic [dtq_pkg::CntW-1:0] One   = dtq_pkg::CntW'(1);
   localparam logic [dtq_pkg::CntW-1:0] Depth = dtq_pkg::CntW'(dtq_pkg::QueueDepth);
   localparam logic [dtq_pkg::CntW-1:0] Limit = dtq_pkg::CntW'(dtq_pkg::MaxFire);

   dtq_pkg::entry_type mem [dtq_pkg::QueueDepth];
   dtq_pkg::entry_type rd_ff;

   logic [dtq_pkg::CntW-1:0]  count_ff, count_in;
   logic [dtq_pkg::CntW-1:0]  ptr_ff, ptr_in;
   logic [dtq_pkg::CntW-1:0]  pos_ff;
   logic [dtq_pkg::CntW-1:0]  fire_ff;
   logic [31:0]               id_ctr_ff;
   logic [1:0]                kind_ff;
   logic [31:0]               now_ff;
   logic [30:0]               delay_ff;
   logic [dtq_pkg::TagW-1:0]  tag_ff;
   logic [31:0]               cid_ff;
   logic [31:0]               item_id_ff;
   logic [2:0]                res_status_ff;
   logic [31:0]               res_id_ff;
   logic                      empty_ff;
   logic [30:0]               ttn_ff;
   logic                      out_valid_ff;
   logic [2:0]                out_status_ff;
   logic [31:0]               out_id_ff;
   logic [dtq_pkg::TagW-1:0]  out_tag_ff;
   logic                      out_last_ff;
   logic                      out_empty_ff;
   logic [30:0]               out_ttn_ff;

   logic [dtq_pkg::CntW-1:0]  rd_idx;
   logic [31:0]               elapsed;
   logic signed [33:0]        remain;
   logic [30:0]               ttn_val;
   dtq_pkg::entry_type        wr_data;

   // remaining ms of the entry in the read register, exact in 34 bits
   assign elapsed = now_ff - rd_ff.start;
   assign remain  = signed'({3'b000, rd_ff.delay}) - signed'({{2{elapsed[31]}}, elapsed});

   always_comb begin
      priority if (remain[33]) begin
         ttn_val = '0;
      end else if (remain[32] || remain[31]) begin
         ttn_val = '1;
      end else begin
         ttn_val = remain[30:0];
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         dtq_pkg::RD_PTR:    rd_idx = ptr_ff;
         dtq_pkg::RD_PTR_M1: rd_idx = ptr_ff - One;
         dtq_pkg::RD_PTR_P1: rd_idx = ptr_ff + One;
         dtq_pkg::RD_TOP:    rd_idx = count_ff - One - ptr_ff;
         default:            rd_idx = ptr_ff;
      endcase
   end

   always_comb begin
      if (cmd.wr_new) begin
         wr_data.start = now_ff;
         wr_data.delay = delay_ff;
         wr_data.tag   = tag_ff;
         wr_data.id    = item_id_ff;
      end else begin
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[ptr_ff[dtq_pkg::AddrW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_idx[dtq_pkg::AddrW-1:0]];
      end
   end

   always_comb begin
      unique case (cmd.ptr_op)
         dtq_pkg::PTR_HOLD:  ptr_in = ptr_ff;
         dtq_pkg::PTR_ZERO:  ptr_in = '0;
         dtq_pkg::PTR_INC:   ptr_in = ptr_ff + One;
         dtq_pkg::PTR_DEC:   ptr_in = ptr_ff - One;
         dtq_pkg::PTR_COUNT: ptr_in = count_ff;
         default:            ptr_in = ptr_ff;
      endcase
      unique case (cmd.cnt_op)
         dtq_pkg::CNT_HOLD: count_in = count_ff;
         dtq_pkg::CNT_INC:  count_in = count_ff + One;
         dtq_pkg::CNT_DEC:  count_in = count_ff - One;
         dtq_pkg::CNT_FIRE: count_in = count_ff - fire_ff;
         default:           count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         id_ctr_ff    <= 32'd1;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (cmd.latch && (req_kind == dtq_pkg::KIND_ADD)) begin
            id_ctr_ff <= id_ctr_ff + 32'd1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff    <= req_kind;
         now_ff     <= req_now_ms;
         delay_ff   <= req_delay_ms[31] ? 31'd0 : req_delay_ms[30:0];
         tag_ff     <= req_tag;
         cid_ff     <= req_cancel_id;
         item_id_ff <= id_ctr_ff;
      end
      if (cmd.pos_load) begin
         pos_ff <= ptr_ff;
      end
      if (cmd.fire_load) begin
         fire_ff <= ptr_ff;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_id_ff     <= cmd.res_use_id ? item_id_ff : 32'd0;
      end
      if (cmd.ttn_clear) begin
         empty_ff <= 1'b1;
         ttn_ff   <= '0;
      end else if (cmd.ttn_load) begin
         empty_ff <= 1'b0;
         ttn_ff   <= ttn_val;
      end
      if (cmd.out_load) begin
         out_last_ff  <= cmd.out_last;
         out_empty_ff <= empty_ff;
         out_ttn_ff   <= ttn_ff;
         if (cmd.out_fire) begin
            out_status_ff <= dtq_pkg::ST_FIRED;
            out_id_ff     <= rd_ff.id;
            out_tag_ff    <= rd_ff.tag;
         end else begin
            out_status_ff <= res_status_ff;
            out_id_ff     <= res_id_ff;
            out_tag_ff    <= '0;
         end
      end
   end

   always_comb begin
      stat.count_full      = (count_ff == Depth);
      stat.ptr_eq_count    = (ptr_ff == count_ff);
      stat.ptr_eq_pos      = (ptr_ff == pos_ff);
      stat.ptr_p1_eq_count = ((ptr_ff + One) == count_ff);
      stat.ptr_eq_max      = (ptr_ff == Limit);
      stat.rem_lt_delay    = signed'({3'b000, delay_ff}) > remain;
      stat.id_match        = (rd_ff.id == cid_ff);
      stat.expired         = remain[33] || (remain == '0);
      stat.is_fire         = (kind_ff == dtq_pkg::KIND_FIRE);
      stat.fire_nz         = (fire_ff != '0);
      stat.ptr_p1_eq_fire  = ((ptr_ff + One) == fire_ff);
      stat.out_free        = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_timer_id     = out_id_ff;
   assign rsp_event_tag    = out_tag_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_queue_empty  = out_empty_ff;
   assign rsp_time_to_next = out_ttn_ff;

endmodule

@@ tb/tb_top.sv @@
// testbench top of the deadline timer queue: directed and random add, cancel and fire beats
// a scoreboard class predicts every result beat and checks them in order; needs dtq_pkg, dtq_if
module tb_top;

   localparam int CycleLimit = 400000;
   localparam int NumRandom  = 440;
   localparam logic [1:0] KindUnused = 2'd3;

   logic clock;
   logic reset;
   bit   calm;
   bit   hold_rsp;
   int   cycles;

   dtq_req_if req_bus ();
   dtq_rsp_if rsp_bus ();

   deadline_timer_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   typedef struct {
      logic [2:0]               status;
      logic [31:0]              id;
      logic [dtq_pkg::TagW-1:0] tag;
      logic                     last;
      logic                     empty;
      logic [30:0]              ttn;
   } result_beat_type;

   class timer_scoreboard;
      logic [31:0]              t_start [dtq_pkg::QueueDepth];
      logic [30:0]              t_delay [dtq_pkg::QueueDepth];
      logic [dtq_pkg::TagW-1:0] t_tag   [dtq_pkg::QueueDepth];
      logic [31:0]              t_id    [dtq_pkg::QueueDepth];
      int                       count;
      logic [31:0]              next_id;
      result_beat_type          expected[$];
      int                       errors;

      function new();
         count   = 0;
         next_id = 1;
         errors  = 0;
      endfunction

      function longint remaining(int i, logic [31:0] now);
         logic [31:0] el;
         el = now - t_start[i];
         return longint'({1'b0, t_delay[i]}) - longint'($signed(el));
      endfunction

      function void move_slot(int dst, int src);
         t_start[dst] = t_start[src];
         t_delay[dst] = t_delay[src];
         t_tag[dst]   = t_tag[src];
         t_id[dst]    = t_id[src];
      endfunction

      function void push_beat(ref result_beat_type beats[$], input logic [2:0] st,
                              input logic [31:0] id, input logic [dtq_pkg::TagW-1:0] tag);
         result_beat_type b;
         b.status = st;
         b.id     = id;
         b.tag    = tag;
         b.last   = 0;
         b.empty  = 0;
         b.ttn    = 0;
         beats.push_back(b);
      endfunction

      function void note_request(logic [1:0] kind, logic [31:0] now, logic [31:0] delay,
                                 logic [dtq_pkg::TagW-1:0] tag, logic [31:0] cid);
         result_beat_type beats[$];
         logic [30:0]     d;
         logic [31:0]     id;
         longint          r;
         int              i;
         int              n;
         if (kind == dtq_pkg::KIND_ADD) begin
            d       = delay[31] ? 31'd0 : delay[30:0];
            id      = next_id;
            next_id = next_id + 1;
            if (count >= dtq_pkg::QueueDepth) begin
               push_beat(beats, dtq_pkg::ST_FULL, 0, 0);
            end else begin
               for (i = 0; i < count; i++)
                  if (longint'({1'b0, d}) > remaining(i, now)) break;
               for (int j = count; j > i; j--) move_slot(j, j - 1);
               t_start[i] = now;
               t_delay[i] = d;
               t_tag[i]   = tag;
               t_id[i]    = id;
               count++;
               push_beat(beats, dtq_pkg::ST_ADDED, id, 0);
            end
         end else if (kind == dtq_pkg::KIND_CANCEL) begin
            for (i = 0; i < count; i++)
               if (t_id[i] == cid) break;
            if (i < count) begin
               for (int j = i; j + 1 < count; j++) move_slot(j, j + 1);
               count--;
               push_beat(beats, dtq_pkg::ST_CANCELLED, 0, 0);
            end else begin
               push_beat(beats, dtq_pkg::ST_NOT_FOUND, 0, 0);
            end
         end else if (kind == dtq_pkg::KIND_FIRE) begin
            n = 0;
            while (count > 0 && n < dtq_pkg::MaxFire) begin
               if (remaining(count - 1, now) > 0) break;
               push_beat(beats, dtq_pkg::ST_FIRED, t_id[count - 1], t_tag[count - 1]);
               count--;
               n++;
            end
            if (n == 0) push_beat(beats, dtq_pkg::ST_NOTHING, 0, 0);
         end else begin
            return;
         end
         r = 0;
         if (count > 0) begin
            r = remaining(count - 1, now);
            if (r < 0) r = 0;
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
         end
         foreach (beats[k]) begin
            beats[k].last  = (k == beats.size() - 1);
            beats[k].empty = (count == 0);
            beats[k].ttn   = r[30:0];
            expected.push_back(beats[k]);
         end
      endfunction

      function void check_result(result_beat_type got);
         result_beat_type want;
         if (expected.size() == 0) begin
            $error("result beat with nothing expected: status %0d id %0d", got.status, got.id);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.id !== want.id) begin
            $error("timer_id: expected %0d, actual %0d", want.id, got.id);
            errors++;
         end
         if (got.tag !== want.tag) begin
            $error("event_tag: expected %0d, actual %0d", want.tag, got.tag);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
         if (got.empty !== want.empty) begin
            $error("queue_empty: expected %0d, actual %0d", want.empty, got.empty);
            errors++;
         end
         if (got.ttn !== want.ttn) begin
            $error("time_to_next: expected %0d, actual %0d", want.ttn, got.ttn);
            errors++;
         end
      endfunction
   endclass

   timer_scoreboard timers = new();

   initial clock = 0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] kind, logic [31:0] now, logic [31:0] delay,
                            logic [dtq_pkg::TagW-1:0] tag, logic [31:0] cid);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid     <= 1;
      req_bus.kind      <= kind;
      req_bus.now_ms    <= now;
      req_bus.delay_ms  <= delay;
      req_bus.tag       <= tag;
      req_bus.cancel_id <= cid;
      do @(posedge clock); while (!req_bus.ready);
      timers.note_request(kind, now, delay, tag, cid);
   endtask

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall;
      int hold_cnt;
      stall    = 0;
      hold_cnt = 0;
      rsp_bus.ready <= 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            timers.check_result('{rsp_bus.status, rsp_bus.timer_id, rsp_bus.event_tag,
                                  rsp_bus.last, rsp_bus.queue_empty, rsp_bus.time_to_next});
         if (hold_rsp) begin
            hold_rsp = 0;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_bus.ready <= 0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 5) - 1;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
         end
      end
   end

   initial begin
      logic [31:0] now;
      logic [31:0] delay;
      logic [31:0] cid;
      logic [1:0]  kind;
      int          pick;
      cycles            = 0;
      calm              = 0;
      hold_rsp          = 0;
      reset             <= 1;
      req_bus.valid     <= 0;
      req_bus.kind      <= dtq_pkg::KIND_ADD;
      req_bus.now_ms    <= 0;
      req_bus.delay_ms  <= 0;
      req_bus.tag       <= 0;
      req_bus.cancel_id <= 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty queue, clamped and extreme delays, equal deadlines, unknown kind
      now = 32'd1000;
      send_item(dtq_pkg::KIND_FIRE,   now, 0, 0, 0);
      send_item(dtq_pkg::KIND_CANCEL, now, 0, 0, 0);
      send_item(dtq_pkg::KIND_ADD,    now, 32'hFFFF_FFFF, 16'hFFFF, 0);
      send_item(dtq_pkg::KIND_ADD,    now, 32'h8000_0000, 16'h0000, 0);
      send_item(dtq_pkg::KIND_ADD,    now, 32'h7FFF_FFFF, 16'h1234, 0);
      send_item(dtq_pkg::KIND_ADD,    now, 32'd10, 16'hA5A5, 0);
      send_item(dtq_pkg::KIND_ADD,    now, 32'd10, 16'h5A5A, 0);
      send_item(KindUnused,           now, 32'd7, 16'h0F0F, 32'd1);
      send_item(dtq_pkg::KIND_CANCEL, now, 0, 0, 32'd3);
      send_item(dtq_pkg::KIND_FIRE,   now, 0, 0, 0);
      now = now + 10;
      send_item(dtq_pkg::KIND_FIRE,   now, 0, 0, 0);
      send_item(dtq_pkg::KIND_CANCEL, now, 0, 0, 32'hFFFF_FFFF);
      // fill across the time wrap, overflow once, then fire all sixteen
      now = 32'hFFFF_FFF8;
      for (int k = 0; k < dtq_pkg::QueueDepth + 1; k++) begin
         send_item(dtq_pkg::KIND_ADD, now, $urandom_range(0, 6),
                   dtq_pkg::TagW'($urandom), 0);
         now = now + 1;
      end
      now = now + 8;
      send_item(dtq_pkg::KIND_FIRE, now, 0, 0, 0);

      for (int n = 0; n < NumRandom; n++) begin
         if (n == 150) hold_rsp = 1;
         if (n == 300) begin
            req_bus.valid <= 0;
            do @(posedge clock); while (timers.expected.size() != 0);
         end
         if (n == NumRandom - 60) calm = 1;
         if ($urandom_range(0, 49) == 0) now = $urandom;
         else now = now + $urandom_range(0, 40);
         pick = $urandom_range(0, 99);
         if (pick < 45) kind = dtq_pkg::KIND_ADD;
         else if (pick < 65) kind = dtq_pkg::KIND_CANCEL;
         else if (pick < 96) kind = dtq_pkg::KIND_FIRE;
         else kind = KindUnused;
         if ($urandom_range(0, 9) == 0) delay = $urandom;
         else delay = $urandom_range(0, 200);
         if ($urandom_range(0, 7) == 0) cid = $urandom;
         else cid = timers.next_id - $urandom_range(1, 20);
         send_item(kind, now, delay, dtq_pkg::TagW'($urandom), cid);
      end

      req_bus.valid <= 0;
      while (timers.expected.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (timers.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

@@ deadline_timer_queue.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_if.sv
rtl/core/dtq_ctrl.sv
rtl/core/dtq_dpath.sv
rtl/core/deadline_timer_queue.sv
tb/tb_top.sv
